>>> rtl/rrbc_pkg.sv
// shared types and constants of the rr interval beat and rhythm classifier
`timescale 1ns / 1ps
`default_nettype none

package rrbc_pkg;

  localparam int POSITION_BITS_DEF = 32;

  // beat types
  typedef enum logic [1:0] {
    BEAT_NORMAL = 2'd0,
    BEAT_VENT   = 2'd1,
    BEAT_OTHER  = 2'd2
  } beat_t;

  // rhythm codes, ordered by severity
  typedef logic [3:0] rhythm_t;
  localparam rhythm_t RHY_NORMAL    = 4'd0;
  localparam rhythm_t RHY_OTHER_PVC = 4'd1;
  localparam rhythm_t RHY_PVC       = 4'd2;
  localparam rhythm_t RHY_PAUSE     = 4'd3;
  localparam rhythm_t RHY_COUPLET   = 4'd4;
  localparam rhythm_t RHY_TRIGEMINY = 4'd5;
  localparam rhythm_t RHY_BIGEMINY  = 4'd6;
  localparam rhythm_t RHY_OTHER_RUN = 4'd7;
  localparam rhythm_t RHY_VENT_RUN  = 4'd8;

  // configuration register indexes
  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CFG_WIDE_QRS_LIMIT = 1'd0;
  localparam cfg_index_t CFG_PAUSE_LIMIT    = 1'd1;

  localparam logic [9:0]  WIDE_QRS_LIMIT_RST = 10'd27;
  localparam logic [15:0] PAUSE_LIMIT_RST    = 16'd300;

  localparam logic [15:0] RR_MAX = 16'hFFFF;

  // premature threshold: rr <= floor((THR_MUL*mean + THR_ADD) / THR_DIV)
  localparam int THR_MUL = 855;
  localparam int THR_ADD = 1060;
  localparam int THR_DIV = 1000;

  // beat and rhythm history, newest type at index 0
  typedef struct packed {
    logic [3:0][15:0] intervals;
    logic [15:0]      mean;
    beat_t [4:0]      types;
    rhythm_t          rhythm_max;
    beat_t            last_type;
  } hist_t;

  typedef struct packed {
    beat_t       beat_type;
    rhythm_t     rhythm_code;
    logic        classified;
    logic [15:0] current_rr;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/rrbc_classify.sv
// combinational beat classification and history update for one word
`timescale 1ns / 1ps
`default_nettype none

module rrbc_classify import rrbc_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic [4:0][POSITION_BITS-1:0] pos_i,
  input  wire hist_t                         hist_i,
  input  wire logic [POSITION_BITS-1:0]      qrs_position,
  input  wire logic [9:0]                    qrs_width,
  input  wire logic                          restart,
  input  wire logic [9:0]                    wide_qrs_limit,
  input  wire logic [15:0]                   pause_limit,
  output logic [4:0][POSITION_BITS-1:0]      pos_o,
  output hist_t                              hist_o,
  output result_t                            res_o
);

  localparam logic [POSITION_BITS-1:0] RrSat = POSITION_BITS'(RR_MAX);

  function automatic logic [15:0] rr_of(input logic [POSITION_BITS-1:0] later,
                                        input logic [POSITION_BITS-1:0] earlier);
    logic [POSITION_BITS-1:0] d;
    d = later - earlier;
    return (d > RrSat) ? RR_MAX : d[15:0];
  endfunction

  logic [5:0][POSITION_BITS-1:0] q;
  logic [3:0][15:0] rr;
  hist_t       hs;
  logic        all_seen;
  logic [15:0] cur;
  logic [26:0] thr_lhs, thr_rhs;
  logic        premature;
  beat_t       t;
  logic        mean_ok;
  logic [17:0] sum_norm, sum_warm;
  rhythm_t     code;
  beat_t       h0, h1, h2, h3, h4;

  // restart clears history first, the previous beat type survives
  always_comb begin
    hs = hist_i;
    if (restart) begin
      hs.intervals  = '0;
      hs.mean       = '0;
      hs.types      = {5{BEAT_NORMAL}};
      hs.rhythm_max = RHY_NORMAL;
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      q[i] = restart ? '0 : pos_i[i];
    end
    q[5] = qrs_position;
  end

  always_comb begin
    all_seen = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (q[i] == '0) all_seen = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      rr[i] = rr_of(q[i+2], q[i+1]);
    end
    for (int i = 0; i < 5; i++) begin
      pos_o[i] = q[i+1];
    end
  end

  assign cur = rr[3];
  assign h0  = hs.types[0];
  assign h1  = hs.types[1];
  assign h2  = hs.types[2];
  assign h3  = hs.types[3];
  assign h4  = hs.types[4];

  // floor(x/1000) >= cur is the same as x >= 1000*cur
  assign thr_lhs   = 27'(cur) * 27'(THR_DIV);
  assign thr_rhs   = 27'(hs.mean) * 27'(THR_MUL) + 27'(THR_ADD);
  assign premature = (thr_lhs <= thr_rhs);

  always_comb begin
    if (!premature) t = BEAT_NORMAL;
    else if (qrs_width >= wide_qrs_limit) t = BEAT_VENT;
    else t = BEAT_OTHER;
  end

  // 0.7*mean < rr < 1.5*mean
  assign mean_ok = ({1'b0, cur, 1'b0} < 18'(hs.mean) * 18'd3) &&
                   (20'(cur) * 20'd10 > 20'(hs.mean) * 20'd7);

  assign sum_norm = 18'(hs.intervals[1]) + 18'(hs.intervals[2]) +
                    18'(hs.intervals[3]) + 18'(cur);
  assign sum_warm = 18'(rr[0]) + 18'(rr[1]) + 18'(rr[2]) + 18'(rr[3]);

  always_comb begin
    priority if (h1 == BEAT_VENT && h0 == BEAT_VENT && t == BEAT_VENT)
      code = RHY_VENT_RUN;
    else if (h1 == BEAT_OTHER && h0 == BEAT_OTHER && t == BEAT_OTHER)
      code = RHY_OTHER_RUN;
    else if (h2 == BEAT_NORMAL && h1 == BEAT_VENT && h0 == BEAT_NORMAL &&
             t == BEAT_VENT)
      code = RHY_BIGEMINY;
    else if (h4 == BEAT_NORMAL && h3 == BEAT_NORMAL && h2 == BEAT_VENT &&
             h1 == BEAT_NORMAL && h0 == BEAT_NORMAL && t == BEAT_VENT)
      code = RHY_TRIGEMINY;
    else if (h4 == BEAT_VENT && h3 == BEAT_VENT && h2 == BEAT_NORMAL &&
             h1 == BEAT_VENT && h0 == BEAT_VENT && t == BEAT_NORMAL)
      code = RHY_TRIGEMINY;
    else if (h0 == BEAT_VENT && t == BEAT_VENT)
      code = RHY_COUPLET;
    else if (cur >= pause_limit)
      code = RHY_PAUSE;
    else if (t == BEAT_VENT)
      code = RHY_PVC;
    else if (t == BEAT_OTHER)
      code = RHY_OTHER_PVC;
    else
      code = RHY_NORMAL;
  end

  always_comb begin
    hist_o = hs;
    res_o.current_rr = cur;
    if (all_seen) begin
      if (t == BEAT_NORMAL && h0 == BEAT_NORMAL && mean_ok) begin
        hist_o.intervals = {cur, hs.intervals[3], hs.intervals[2], hs.intervals[1]};
        hist_o.mean      = sum_norm[17:2];
      end
      if (code > hs.rhythm_max) hist_o.rhythm_max = code;
      hist_o.types     = {hs.types[3:0], t};
      hist_o.last_type = t;
      res_o.beat_type  = t;
      res_o.classified = 1'b1;
    end else begin
      // warm-up: seed the intervals with the latest rr values
      hist_o.intervals  = rr;
      hist_o.mean       = sum_warm[17:2];
      hist_o.types      = {hs.types[3:0], hs.last_type};
      hist_o.rhythm_max = RHY_NORMAL;
      hist_o.last_type  = BEAT_NORMAL;
      res_o.beat_type   = BEAT_NORMAL;
      res_o.classified  = 1'b0;
    end
    res_o.rhythm_code = hist_o.rhythm_max;
  end

endmodule

`default_nettype wire

>>> rtl/rr_interval_beat_rhythm_classifier.sv
// top level of the rr interval beat and rhythm classifier
// usage:
//   input channel: one word per detected heartbeat (qrs position, qrs width,
//   restart). a word is taken on a rising edge with in_valid high and
//   in_stall low.
//   result channel: one word per input word (beat type, rhythm code,
//   classified flag, current rr), taken on a rising edge with out_valid high
//   and out_stall low.
//   config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready;
//   cfg_ready is always high. write only while the block is idle.
// path: an accepted word waits in the input register, its result then waits in the result register.
// throughput: one word per cycle while out_stall is low; the single stage between the input
//   register and the result register holds all of the classification math.
// reset: rst_n low clears the history, the rhythm maximum, the valid flags
//   and loads the default wide qrs and pause limits.
// stall: while out_stall holds a result, the next word waits in the input
//   register; in_stall rises only when that register is also full.
`timescale 1ns / 1ps
`default_nettype none

module rr_interval_beat_rhythm_classifier import rrbc_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [POSITION_BITS-1:0] in_qrs_position,
  input  wire logic [9:0]               in_qrs_width,
  input  wire logic                     in_restart,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_beat_type,
  output logic [3:0]                    out_rhythm_code,
  output logic                          out_classified,
  output logic [15:0]                   out_current_rr,
  // config channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire cfg_index_t               cfg_index,
  input  wire logic [15:0]              cfg_data
);

  // config registers
  logic [9:0]  wide_qrs_limit_r;
  logic [15:0] pause_limit_r;

  // input register
  logic                     s1_valid_r, s1_valid_nxt;
  logic [POSITION_BITS-1:0] s1_position_r;
  logic [9:0]               s1_width_r;
  logic                     s1_restart_r;

  // beat history
  logic [4:0][POSITION_BITS-1:0] pos_r, pos_nxt;
  hist_t                         hist_r, hist_nxt;
  result_t                       res;

  // result register
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;

  logic in_acc;
  logic adv;

  // the word in the input register moves on when the result slot is free
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  rrbc_classify #(
    .POSITION_BITS(POSITION_BITS)
  ) u_classify (
    .pos_i         (pos_r),
    .hist_i        (hist_r),
    .qrs_position  (s1_position_r),
    .qrs_width     (s1_width_r),
    .restart       (s1_restart_r),
    .wide_qrs_limit(wide_qrs_limit_r),
    .pause_limit   (pause_limit_r),
    .pos_o         (pos_nxt),
    .hist_o        (hist_nxt),
    .res_o         (res)
  );

  // control state and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      wide_qrs_limit_r  <= WIDE_QRS_LIMIT_RST;
      pause_limit_r     <= PAUSE_LIMIT_RST;
      pos_r             <= '0;
      hist_r.intervals  <= '0;
      hist_r.mean       <= '0;
      hist_r.types      <= {5{BEAT_NORMAL}};
      hist_r.rhythm_max <= RHY_NORMAL;
      hist_r.last_type  <= BEAT_NORMAL;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WIDE_QRS_LIMIT: wide_qrs_limit_r <= cfg_data[9:0];
          CFG_PAUSE_LIMIT:    pause_limit_r    <= cfg_data;
        endcase
      end
      if (adv) begin
        pos_r  <= pos_nxt;
        hist_r <= hist_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_position_r <= in_qrs_position;
      s1_width_r    <= in_qrs_width;
      s1_restart_r  <= in_restart;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_beat_type   = out_r.beat_type;
  assign out_rhythm_code = out_r.rhythm_code;
  assign out_classified  = out_r.classified;
  assign out_current_rr  = out_r.current_rr;

  // a warm-up result is always normal with a clear rhythm
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.classified |->
      out_r.beat_type == BEAT_NORMAL && out_r.rhythm_code == RHY_NORMAL)
    else $error("warm-up result carries a beat type or rhythm");

  // the rhythm maximum only grows across classified beats without restart
  assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.classified && !s1_restart_r |=>
      hist_r.rhythm_max >= $past(hist_r.rhythm_max))
    else $error("rhythm maximum dropped");

  // history moves only when a word is processed
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(hist_r.mean) && $stable(hist_r.types))
    else $error("history changed without a word");

  // stalling the input means the input register is full
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room available");

endmodule

`default_nettype wire

>>> sim/rr_interval_beat_rhythm_classifier_tb.sv
// self-checking testbench: directed beat table, then random rhythm segments under several limits
`timescale 1ns / 1ps

module rr_interval_beat_rhythm_classifier_tb import rrbc_pkg::*;;

  // run length and safety net
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 190;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int NUM_ROWS        = 28;

  // shapes of the random rhythm segments
  typedef enum int {
    PLAN_FREE,
    PLAN_BIGEMINY,
    PLAN_TRIGEMINY,
    PLAN_PAIRS,
    PLAN_VENT_RUN,
    PLAN_OTHER_RUN
  } rhythm_plan_t;

  typedef enum int {
    KIND_NORMAL,
    KIND_VENT,
    KIND_OTHER,
    KIND_PAUSE
  } beat_kind_t;

  // one row of the directed table; want is only used when typed is set
  typedef struct packed {
    logic [31:0] pos;
    logic [9:0]  width;
    logic        restart;
    logic        typed;
    result_t     want;
  } beat_row_t;

  localparam result_t UNTYPED = '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd0};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_qrs_position;
  logic [9:0]  in_qrs_width;
  logic        in_restart;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_beat_type;
  logic [3:0]  out_rhythm_code;
  logic        out_classified;
  logic [15:0] out_current_rr;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [15:0] cfg_data;

  rr_interval_beat_rhythm_classifier dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_qrs_position (in_qrs_position),
    .in_qrs_width    (in_qrs_width),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_beat_type   (out_beat_type),
    .out_rhythm_code (out_rhythm_code),
    .out_classified  (out_classified),
    .out_current_rr  (out_current_rr),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // directed beats: warm-up, ectopic patterns, pause, restart, wrap and zero position
  // mean settles at 100 samples, so anything at or below 86 is premature
  beat_row_t beat_table [NUM_ROWS] = '{
    // warm-up from reset: rr is plain position difference
    '{32'd100,  10'd10,   1'b0, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd100}},
    '{32'd200,  10'd10,   1'b0, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd100}},
    '{32'd300,  10'd10,   1'b0, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd100}},
    '{32'd400,  10'd10,   1'b0, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd100}},
    '{32'd500,  10'd10,   1'b0, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd100}},
    // first classified beat, then single pvc, bigeminy, couplet, ventricular run
    '{32'd600,  10'd10,   1'b0, 1'b0, UNTYPED},
    '{32'd660,  10'd40,   1'b0, 1'b0, UNTYPED},
    '{32'd760,  10'd10,   1'b0, 1'b0, UNTYPED},
    '{32'd820,  10'd40,   1'b0, 1'b0, UNTYPED},
    '{32'd880,  10'd40,   1'b0, 1'b0, UNTYPED},
    '{32'd940,  10'd40,   1'b0, 1'b0, UNTYPED},
    // narrow premature beats into a run, width down to zero
    '{32'd1000, 10'd5,    1'b0, 1'b0, UNTYPED},
    '{32'd1060, 10'd5,    1'b0, 1'b0, UNTYPED},
    '{32'd1120, 10'd0,    1'b0, 1'b0, UNTYPED},
    // long pause with the widest qrs
    '{32'd1520, 10'd1023, 1'b0, 1'b0, UNTYPED},
    // restart clears the history but the previous beat type, the new warm-up sees only this position
    '{32'd2000, 10'd10,   1'b1, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd2000}},
    '{32'd2100, 10'd10,   1'b0, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd100}},
    '{32'd2200, 10'd10,   1'b0, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd100}},
    '{32'd2300, 10'd10,   1'b0, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd100}},
    '{32'd2400, 10'd10,   1'b0, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'd100}},
    // normal, pvc, two normals, pvc: trigeminy
    '{32'd2500, 10'd10,   1'b0, 1'b0, UNTYPED},
    '{32'd2560, 10'd1023, 1'b0, 1'b0, UNTYPED},
    '{32'd2660, 10'd10,   1'b0, 1'b0, UNTYPED},
    '{32'd2760, 10'd10,   1'b0, 1'b0, UNTYPED},
    '{32'd2820, 10'd40,   1'b0, 1'b0, UNTYPED},
    // huge jump saturates rr, then wrap past the top of the position range
    '{32'hFFFF_FFC0, 10'd512, 1'b0, 1'b0, UNTYPED},
    '{32'h0000_0010, 10'd0,   1'b0, 1'b0, UNTYPED},
    // zero position means no beat: back to warm-up, rr wraps to saturation
    '{32'd0,    10'd10,   1'b0, 1'b1, '{BEAT_NORMAL, RHY_NORMAL, 1'b0, 16'hFFFF}}
  };

  // predictor state
  logic [31:0] pos_hist [5];
  logic [15:0] nn_rr [4];
  logic [15:0] nn_mean;
  beat_t       type_hist [5];
  rhythm_t     worst_rhythm;
  beat_t       prev_type;
  logic [9:0]  wide_lim;
  logic [15:0] pause_lim;

  // expected result words, oldest first
  result_t pending_results [$];

  // random stimulus state
  logic [31:0]    gen_pos;
  int unsigned    base_rr;
  rhythm_plan_t   plan;
  int unsigned    plan_step;
  int             seg_left;

  int errors;
  int cycles;
  int send_calm;
  int recv_calm;

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // wait length for one word: 0 to 14, with calm stretches of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < 5; i++) begin
      pos_hist[i]  = '0;
      type_hist[i] = BEAT_NORMAL;
    end
    for (int i = 0; i < 4; i++) nn_rr[i] = '0;
    nn_mean      = '0;
    worst_rhythm = RHY_NORMAL;
  endfunction

  // classify one beat and advance the predictor history
  function automatic result_t classify_beat(input logic [31:0] pos, input logic [9:0] width,
                                            input logic restart);
    logic [31:0] seen [6];
    logic [31:0] diff;
    logic [15:0] rr [4];
    logic [15:0] cur;
    int unsigned thr;
    int unsigned sum;
    bit          all_seen;
    bit          refresh_mean;
    beat_t       t;
    beat_t       shifted;
    rhythm_t     code;
    result_t     r;

    if (restart) clear_history();

    for (int i = 0; i < 5; i++) seen[i] = pos_hist[i];
    seen[5] = pos;
    for (int i = 0; i < 5; i++) pos_hist[i] = seen[i + 1];

    // six nonzero positions end the warm-up
    all_seen = 1'b1;
    for (int i = 0; i < 6; i++) if (seen[i] == 32'd0) all_seen = 1'b0;

    // intervals wrap modulo the position width and saturate at 16 bits
    for (int i = 0; i < 4; i++) begin
      diff  = seen[i + 2] - seen[i + 1];
      rr[i] = (diff > 32'd65535) ? 16'hFFFF : diff[15:0];
    end
    cur          = rr[3];
    t            = BEAT_NORMAL;
    refresh_mean = 1'b0;

    if (all_seen) begin
      // premature threshold 0.855 * mean, rounded the way the block does it
      thr = (32'd855 * 32'(nn_mean) + 32'd1060) / 32'd1000;
      if (32'(cur) <= thr) t = (width >= wide_lim) ? BEAT_VENT : BEAT_OTHER;

      // only a plausible normal-to-normal interval feeds the mean
      if (t == BEAT_NORMAL && type_hist[0] == BEAT_NORMAL &&
          32'd2 * 32'(cur) < 32'd3 * 32'(nn_mean) &&
          32'd10 * 32'(cur) > 32'd7 * 32'(nn_mean)) begin
        nn_rr[0]     = nn_rr[1];
        nn_rr[1]     = nn_rr[2];
        nn_rr[2]     = nn_rr[3];
        nn_rr[3]     = cur;
        refresh_mean = 1'b1;
      end

      // rhythm patterns, most severe first
      if (type_hist[1] == BEAT_VENT && type_hist[0] == BEAT_VENT && t == BEAT_VENT)
        code = RHY_VENT_RUN;
      else if (type_hist[1] == BEAT_OTHER && type_hist[0] == BEAT_OTHER && t == BEAT_OTHER)
        code = RHY_OTHER_RUN;
      else if (type_hist[2] == BEAT_NORMAL && type_hist[1] == BEAT_VENT &&
               type_hist[0] == BEAT_NORMAL && t == BEAT_VENT)
        code = RHY_BIGEMINY;
      else if (type_hist[4] == BEAT_NORMAL && type_hist[3] == BEAT_NORMAL &&
               type_hist[2] == BEAT_VENT && type_hist[1] == BEAT_NORMAL &&
               type_hist[0] == BEAT_NORMAL && t == BEAT_VENT)
        code = RHY_TRIGEMINY;
      else if (type_hist[4] == BEAT_VENT && type_hist[3] == BEAT_VENT &&
               type_hist[2] == BEAT_NORMAL && type_hist[1] == BEAT_VENT &&
               type_hist[0] == BEAT_VENT && t == BEAT_NORMAL)
        code = RHY_TRIGEMINY;
      else if (type_hist[0] == BEAT_VENT && t == BEAT_VENT)
        code = RHY_COUPLET;
      else if (cur >= pause_lim)
        code = RHY_PAUSE;
      else if (t == BEAT_VENT)
        code = RHY_PVC;
      else if (t == BEAT_OTHER)
        code = RHY_OTHER_PVC;
      else
        code = RHY_NORMAL;

      if (code > worst_rhythm) worst_rhythm = code;
      shifted = t;
    end else begin
      // warm-up: take the latest intervals as they are, previous type goes into history
      for (int i = 0; i < 4; i++) nn_rr[i] = rr[i];
      refresh_mean = 1'b1;
      shifted      = prev_type;
      worst_rhythm = RHY_NORMAL;
    end

    if (refresh_mean) begin
      sum     = 32'(nn_rr[0]) + 32'(nn_rr[1]) + 32'(nn_rr[2]) + 32'(nn_rr[3]);
      nn_mean = 16'(sum >> 2);
    end

    for (int i = 4; i > 0; i--) type_hist[i] = type_hist[i - 1];
    type_hist[0] = shifted;
    prev_type    = t;

    r.beat_type   = t;
    r.rhythm_code = worst_rhythm;
    r.classified  = all_seen;
    r.current_rr  = cur;
    return r;
  endfunction

  // present one word after a random gap, hold it until accepted, queue its result
  task automatic send_beat(input logic [31:0] pos, input logic [9:0] width,
                           input logic restart, input logic typed, input result_t want);
    int      gap;
    result_t predicted;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_qrs_position = pos;
    in_qrs_width    = width;
    in_restart      = restart;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = classify_beat(pos, width, restart);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // sender holds off until every queued result has come back
  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == CFG_WIDE_QRS_LIMIT) wide_lim = data[9:0];
    else pause_lim = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // next random beat: segments of one rhythm plan, each opened by a restart,
  // with a little noise (zero, random, backward and far positions, stray restarts)
  task automatic next_random_beat(output logic [31:0] pos, output logic [9:0] width,
                                  output logic restart);
    int unsigned pick;
    int unsigned rr;
    beat_kind_t  kind;
    beat_kind_t  free_kind;
    restart = 1'b0;
    width   = 10'($urandom_range(0, 1023));

    if (seg_left <= 0) begin
      seg_left  = $urandom_range(15, 60);
      base_rr   = ($urandom_range(0, 4) == 0) ? $urandom_range(1200, 40000)
                                               : $urandom_range(40, 1200);
      plan      = rhythm_plan_t'($urandom_range(0, 5));
      plan_step = 0;
      gen_pos   = $urandom;
      pos       = gen_pos;
      restart   = 1'b1;
      return;
    end
    seg_left--;

    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      pos = gen_pos;
      case ($urandom_range(0, 4))
        0: pos = 32'd0;
        1: gen_pos = $urandom;
        2: gen_pos = gen_pos - $urandom_range(1, 5000);
        3: gen_pos = gen_pos + $urandom_range(65536, 1 << 24);
        default: begin
          restart = 1'b1;
          gen_pos = gen_pos + base_rr;
        end
      endcase
      if (pos != 32'd0) pos = gen_pos;
      return;
    end

    pick = $urandom_range(0, 99);
    if (pick < 65) free_kind = KIND_NORMAL;
    else if (pick < 78) free_kind = KIND_VENT;
    else if (pick < 90) free_kind = KIND_OTHER;
    else free_kind = KIND_PAUSE;

    plan_step++;
    case (plan)
      PLAN_BIGEMINY:  kind = (plan_step % 2 == 0) ? KIND_VENT : KIND_NORMAL;
      PLAN_TRIGEMINY: kind = (plan_step % 3 == 0) ? KIND_VENT : KIND_NORMAL;
      PLAN_PAIRS:     kind = (plan_step % 3 != 0) ? KIND_VENT : KIND_NORMAL;
      PLAN_VENT_RUN:  kind = (plan_step % 6 < 3) ? KIND_VENT : KIND_NORMAL;
      PLAN_OTHER_RUN: kind = (plan_step % 6 < 3) ? KIND_OTHER : KIND_NORMAL;
      default:        kind = free_kind;
    endcase
    // an occasional off-pattern beat
    if ($urandom_range(0, 11) == 0) kind = free_kind;

    case (kind)
      KIND_VENT: begin
        rr    = base_rr * $urandom_range(30, 80) / 100;
        width = 10'($urandom_range(wide_lim, 1023));
      end
      KIND_OTHER: begin
        rr    = base_rr * $urandom_range(30, 80) / 100;
        width = 10'($urandom_range(0, wide_lim - 1));
      end
      KIND_PAUSE: rr = base_rr * $urandom_range(160, 500) / 100;
      default:    rr = base_rr * $urandom_range(93, 107) / 100;
    endcase
    if (rr == 0) rr = 1;
    gen_pos = gen_pos + rr;
    pos     = gen_pos;
  endtask

  // result side: random stall per word, sampled at the rising edge
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = draw_wait(recv_calm);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: type %0d rhythm %0d cls %0d rr %0d", $time,
                 out_beat_type, out_rhythm_code, out_classified, out_current_rr);
      end else begin
        want = pending_results.pop_front();
        if (out_beat_type !== want.beat_type) begin
          errors++;
          $display("%0t: beat_type expected %0d actual %0d", $time, want.beat_type,
                   out_beat_type);
        end
        if (out_rhythm_code !== want.rhythm_code) begin
          errors++;
          $display("%0t: rhythm_code expected %0d actual %0d", $time, want.rhythm_code,
                   out_rhythm_code);
        end
        if (out_classified !== want.classified) begin
          errors++;
          $display("%0t: classified expected %0d actual %0d", $time, want.classified,
                   out_classified);
        end
        if (out_current_rr !== want.current_rr) begin
          errors++;
          $display("%0t: current_rr expected %0d actual %0d", $time, want.current_rr,
                   out_current_rr);
        end
      end
    end
  end

  // main sequence: reset, directed table, then random phases under changing limits
  initial begin
    logic [31:0] pos;
    logic [9:0]  width;
    logic        restart;
    logic [9:0]  wide_pick;
    logic [15:0] pause_pick;

    errors          = 0;
    cycles          = 0;
    send_calm       = 0;
    recv_calm       = 0;
    seg_left        = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_qrs_position = '0;
    in_qrs_width    = '0;
    in_restart      = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_WIDE_QRS_LIMIT;
    cfg_data        = '0;

    // predictor starts from the reset defaults
    clear_history();
    prev_type = BEAT_NORMAL;
    wide_lim  = 10'd27;
    pause_lim = 16'd300;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_ROWS; i++)
      send_beat(beat_table[i].pos, beat_table[i].width, beat_table[i].restart,
                beat_table[i].typed, beat_table[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      // limits change only with the block idle
      wait_results_drained();
      repeat (3) @(negedge clk);
      case (ph)
        0: begin
          wide_pick  = 10'd27;
          pause_pick = 16'd300;
        end
        1: begin
          wide_pick  = 10'd1;
          pause_pick = 16'd1;
        end
        2: begin
          wide_pick  = 10'd1023;
          pause_pick = 16'd65535;
        end
        default: begin
          wide_pick  = 10'($urandom_range(1, 1023));
          pause_pick = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 65535))
                                                   : 16'($urandom_range(100, 3000));
        end
      endcase
      // upper data bits are junk for the width register
      write_reg(CFG_WIDE_QRS_LIMIT, {6'($urandom_range(0, 63)), wide_pick});
      write_reg(CFG_PAUSE_LIMIT, pause_pick);
      seg_left = 0;

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        next_random_beat(pos, width, restart);
        send_beat(pos, width, restart, 1'b0, UNTYPED);
        if ($urandom_range(0, 149) == 0) wait_results_drained();
      end
    end

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
